// File: rtl/core/plp_pkg.sv
// plp_pkg: shared constants, codes and control/status structs for the positional list unit
// depends on nothing; used by plp_ctrl, plp_dp and the top level
package plp_pkg;

  localparam int DEPTH  = 256;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  typedef struct packed {
    logic load;
    logic check;
    logic shift_init;
    logic shift_step;
    logic commit;
    logic read;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic ins_ok;
    logic del_ok;
    logic rd_ok;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/plp_ram.sv
// plp_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module plp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/plp_ctrl.sv
// plp_ctrl: sequencing state machine of the positional list unit
// depends on plp_pkg; drives plp_dp through ctl_t, watches sts_t
module plp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  plp_pkg::sts_t sts,
  output plp_pkg::ctl_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        if (sts.ins_ok || sts.del_ok) begin
          ctl.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else if (sts.rd_ok) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SHIFT: begin
        ctl.shift_step = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_READ: begin
        ctl.read  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: rtl/core/plp_dp.sv
// plp_dp: entry ram, length counter, shift addressing and result register
// depends on plp_pkg and plp_ram; controlled by plp_ctrl
module plp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  plp_pkg::ctl_t                ctl,
  output plp_pkg::sts_t                sts,
  input  logic [plp_pkg::CMD_W-1:0]    in_command,
  input  logic [plp_pkg::POS_W-1:0]    in_position,
  input  logic [plp_pkg::WORD_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plp_pkg::STAT_W-1:0]   out_status,
  output logic [plp_pkg::WORD_W-1:0]   out_read_value,
  output logic [plp_pkg::LEN_W-1:0]    out_length
);

  logic [plp_pkg::CMD_W-1:0]  cmd_r;
  logic [plp_pkg::POS_W-1:0]  pos_r;
  logic [plp_pkg::WORD_W-1:0] val_r;
  logic [plp_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [plp_pkg::CW-1:0]     count_r, count_nxt;
  logic [plp_pkg::CW-1:0]     rem_r;
  logic [plp_pkg::AW-1:0]     idx_r;
  logic [plp_pkg::AW-1:0]     pend_addr_r;
  logic                       pend_r, pend_nxt;
  logic                       up_r;
  logic                       out_valid_r;
  logic [plp_pkg::STAT_W-1:0] out_status_r;
  logic [plp_pkg::WORD_W-1:0] out_read_value_r;
  logic [plp_pkg::LEN_W-1:0]  out_length_r;

  logic [plp_pkg::CMP_W-1:0]  cnt_ext, pos_ext;
  logic [plp_pkg::AW-1:0]     pos0;
  logic                       full, pos_nz, ins_ok, del_ok, rd_ok, step_rd, out_free;

  logic                       ram_we, ram_re;
  logic [plp_pkg::AW-1:0]     ram_waddr, ram_raddr;
  logic [plp_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  assign cnt_ext = plp_pkg::CMP_W'(count_r);
  assign pos_ext = plp_pkg::CMP_W'(pos_r);
  assign pos0    = plp_pkg::AW'(pos_ext - 1'b1);
  assign full    = (count_r == plp_pkg::CW'(plp_pkg::DEPTH));
  assign pos_nz  = (pos_r != '0);
  assign ins_ok  = (cmd_r == plp_pkg::CMD_INSERT) && !full && pos_nz &&
                   (pos_ext <= cnt_ext + 1'b1);
  assign del_ok  = (cmd_r == plp_pkg::CMD_DELETE) && pos_nz && (pos_ext <= cnt_ext);
  assign rd_ok   = (cmd_r == plp_pkg::CMD_READ) && pos_nz && (pos_ext <= cnt_ext);
  assign step_rd = ctl.shift_step && (rem_r != '0);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if ((cmd_r == plp_pkg::CMD_INSERT) && full) begin
      stat_nxt = plp_pkg::ST_FULL;
    end else if (ins_ok || del_ok || rd_ok) begin
      stat_nxt = plp_pkg::ST_OK;
    end else begin
      stat_nxt = plp_pkg::ST_BADPOS;
    end
  end

  always_comb begin
    sts.ins_ok     = ins_ok;
    sts.del_ok     = del_ok;
    sts.rd_ok      = rd_ok;
    sts.shift_done = (rem_r == '0) && !pend_r;
    sts.out_free   = out_free;
  end

  // shift pipeline: read one entry, write it one place over in the next cycle
  assign pend_nxt  = step_rd;
  assign ram_re    = step_rd || ctl.read;
  assign ram_raddr = ctl.read ? pos0 : idx_r;
  assign ram_we    = pend_r || (ctl.commit && up_r);
  assign ram_waddr = pend_r ? pend_addr_r : pos0;
  assign ram_wdata = pend_r ? ram_rdata : val_r;

  always_comb begin
    count_nxt = count_r;
    if (ctl.commit) begin
      count_nxt = up_r ? count_r + 1'b1 : count_r - 1'b1;
    end
  end

  plp_ram #(
    .WIDTH (plp_pkg::WORD_W),
    .DEPTH (plp_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (ctl.check) begin
      stat_r <= stat_nxt;
    end
    if (ctl.shift_init) begin
      up_r <= ins_ok;
      if (ins_ok) begin
        rem_r <= plp_pkg::CW'(cnt_ext + 1'b1 - pos_ext);
        idx_r <= plp_pkg::AW'(cnt_ext - 1'b1);
      end else begin
        rem_r <= plp_pkg::CW'(cnt_ext - pos_ext);
        idx_r <= plp_pkg::AW'(pos_ext);
      end
    end else if (step_rd) begin
      rem_r       <= rem_r - 1'b1;
      idx_r       <= up_r ? idx_r - 1'b1 : idx_r + 1'b1;
      pend_addr_r <= up_r ? idx_r + 1'b1 : idx_r - 1'b1;
    end
    if (ctl.emit) begin
      out_status_r     <= stat_r;
      out_read_value_r <= ((cmd_r == plp_pkg::CMD_READ) && (stat_r == plp_pkg::ST_OK)) ?
                          ram_rdata : '0;
      out_length_r     <= plp_pkg::LEN_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_length     = out_length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= plp_pkg::CW'(plp_pkg::DEPTH))
    else $error("list length above depth");

  a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |-> $past(ctl.commit))
    else $error("length changed outside commit");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |->
      (count_r == plp_pkg::CW'($past(count_r) + 1'b1) ||
       count_r == plp_pkg::CW'($past(count_r) - 1'b1)))
    else $error("length moved by more than one");

  a_commit_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !pend_r)
    else $error("commit collides with shift write");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> out_free)
    else $error("result overwrites untaken result");

endmodule

// File: rtl/core/positional_list_insert_delete_unit.sv
// channel   dir  handshake            payload
// in_       in   in_valid/in_ready    in_command, in_position, in_value
// out_      out  out_valid/out_ready  out_status, out_read_value, out_length
//
// one command at a time; a failed command goes from check straight to result, a read through one ram read
// insert/delete shift the entries behind the position, then commit; the shift moves one ram word per cycle
// synchronous active-low reset clears length, state and result valid; ram contents are kept
// a stalled result holds the next command out only once that command is ready to report
// depends on plp_pkg, plp_ctrl, plp_dp, plp_ram
module positional_list_insert_delete_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [plp_pkg::CMD_W-1:0]    in_command,
  input  logic [plp_pkg::POS_W-1:0]    in_position,
  input  logic [plp_pkg::WORD_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plp_pkg::STAT_W-1:0]   out_status,
  output logic [plp_pkg::WORD_W-1:0]   out_read_value,
  output logic [plp_pkg::LEN_W-1:0]    out_length
);

  plp_pkg::ctl_t ctl;
  plp_pkg::sts_t sts;

  plp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  plp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length)
  );

endmodule

// File: bench/positional_list_insert_delete_unit_tb.sv
// self-checking bench for positional_list_insert_delete_unit: directed, fill, stall and random list edits
// predicts every result with its own list model and compares field by field; depends on plp_pkg
`timescale 1ns / 100ps

module positional_list_insert_delete_unit_tb;

  localparam int HOLD_CYCLES = 1000;
  localparam logic [plp_pkg::CMD_W-1:0] CMD_RSVD = 2'd3;

  typedef struct packed {
    logic [plp_pkg::STAT_W-1:0] status;
    logic [plp_pkg::WORD_W-1:0] read_value;
    logic [plp_pkg::LEN_W-1:0]  length;
  } list_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [plp_pkg::CMD_W-1:0]    in_command;
  logic [plp_pkg::POS_W-1:0]    in_position;
  logic [plp_pkg::WORD_W-1:0]   in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [plp_pkg::STAT_W-1:0]   out_status;
  logic [plp_pkg::WORD_W-1:0]   out_read_value;
  logic [plp_pkg::LEN_W-1:0]    out_length;

  logic [plp_pkg::WORD_W-1:0]   list_words [0:plp_pkg::DEPTH-1];
  int                           list_len;
  list_result_t                 pending_results [$];
  int                           mismatch_count;
  bit                           idle_on;
  bit                           hold_off_req;

  positional_list_insert_delete_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // list model: applies one command and returns its result
  function automatic list_result_t apply_list_op(logic [plp_pkg::CMD_W-1:0] cmd,
                                                 logic [plp_pkg::POS_W-1:0] pos,
                                                 logic [plp_pkg::WORD_W-1:0] val);
    list_result_t r;
    int k;
    r.status     = plp_pkg::ST_BADPOS;
    r.read_value = '0;
    case (cmd)
      plp_pkg::CMD_INSERT: begin
        if (list_len >= plp_pkg::DEPTH) begin
          r.status = plp_pkg::ST_FULL;
        end else if (pos >= 1 && pos <= list_len + 1) begin
          for (k = list_len; k >= pos; k--) list_words[k] = list_words[k-1];
          list_words[pos-1] = val;
          list_len++;
          r.status = plp_pkg::ST_OK;
        end
      end
      plp_pkg::CMD_DELETE: begin
        if (pos >= 1 && pos <= list_len) begin
          for (k = pos; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
          r.status = plp_pkg::ST_OK;
        end
      end
      plp_pkg::CMD_READ: begin
        if (pos >= 1 && pos <= list_len) begin
          r.read_value = list_words[pos-1];
          r.status     = plp_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.length = list_len[plp_pkg::LEN_W-1:0];
    return r;
  endfunction

  task automatic send_op(logic [plp_pkg::CMD_W-1:0] cmd, logic [plp_pkg::POS_W-1:0] pos,
                         logic [plp_pkg::WORD_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_list_op(cmd, pos, val));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    int pick;
    logic [plp_pkg::CMD_W-1:0] cmd;
    logic [plp_pkg::POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    if (list_len == 0 && pick < 80) pick = 40;
    if (pick < 30) begin
      cmd = plp_pkg::CMD_READ;
      pos = plp_pkg::POS_W'($urandom_range(1, list_len));
    end else if (pick < 55) begin
      cmd = plp_pkg::CMD_INSERT;
      pos = plp_pkg::POS_W'($urandom_range(1, list_len + 1));
    end else if (pick < 80) begin
      cmd = plp_pkg::CMD_DELETE;
      pos = plp_pkg::POS_W'($urandom_range(1, list_len));
    end else if (pick < 92) begin
      cmd = plp_pkg::CMD_W'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) pos = '0;
      else pos = plp_pkg::POS_W'($urandom_range(
                   list_len + ((cmd == plp_pkg::CMD_INSERT) ? 2 : 1), 511));
    end else begin
      cmd = CMD_RSVD;
      pos = plp_pkg::POS_W'($urandom_range(0, 511));
    end
    send_op(cmd, pos, $urandom);
  endtask

  task automatic test_empty_list();
    send_op(plp_pkg::CMD_READ, 9'd1, 32'h0);
    send_op(plp_pkg::CMD_DELETE, 9'd1, 32'h0);
    send_op(plp_pkg::CMD_INSERT, 9'd0, 32'hFFFF_FFFF);
    send_op(plp_pkg::CMD_INSERT, 9'd2, 32'h1);
    send_op(CMD_RSVD, 9'd0, 32'h0);
    wait_all_results();
  endtask

  task automatic test_basic_edits();
    int p;
    send_op(plp_pkg::CMD_INSERT, 9'd1, 32'h0000_0000);
    send_op(plp_pkg::CMD_INSERT, 9'd2, 32'hFFFF_FFFF);
    send_op(plp_pkg::CMD_INSERT, 9'd1, 32'hA5A5_A5A5);
    send_op(plp_pkg::CMD_INSERT, 9'd3, 32'h5A5A_5A5A);
    send_op(plp_pkg::CMD_INSERT, 9'd5, 32'h1234_5678);
    for (p = 1; p <= 5; p++) send_op(plp_pkg::CMD_READ, p[plp_pkg::POS_W-1:0], 32'h0);
    send_op(plp_pkg::CMD_READ, 9'd6, 32'h0);
    send_op(plp_pkg::CMD_READ, 9'd511, 32'h0);
    send_op(plp_pkg::CMD_INSERT, 9'd7, 32'hDEAD_BEEF);
    send_op(plp_pkg::CMD_DELETE, 9'd3, 32'h0);
    send_op(plp_pkg::CMD_READ, 9'd3, 32'h0);
    send_op(plp_pkg::CMD_DELETE, 9'd4, 32'h0);
    send_op(plp_pkg::CMD_DELETE, 9'd1, 32'h0);
    send_op(plp_pkg::CMD_READ, 9'd1, 32'h0);
    send_op(plp_pkg::CMD_READ, 9'd2, 32'h0);
    send_op(plp_pkg::CMD_DELETE, 9'd0, 32'h0);
    send_op(CMD_RSVD, 9'd1, 32'hFFFF_FFFF);
    wait_all_results();
  endtask

  task automatic test_fill_to_full();
    logic [plp_pkg::POS_W-1:0] pos;
    while (list_len < plp_pkg::DEPTH) begin
      if ($urandom_range(0, 15) == 0) pos = plp_pkg::POS_W'($urandom_range(1, list_len + 1));
      else pos = plp_pkg::POS_W'(list_len + 1);
      send_op(plp_pkg::CMD_INSERT, pos, $urandom);
    end
    send_op(plp_pkg::CMD_INSERT, 9'd1, $urandom);
    send_op(plp_pkg::CMD_INSERT, 9'd0, $urandom);
    send_op(plp_pkg::CMD_INSERT, 9'd300, $urandom);
    send_op(plp_pkg::CMD_READ, 9'd256, 32'h0);
    send_op(plp_pkg::CMD_READ, 9'd257, 32'h0);
    send_op(plp_pkg::CMD_DELETE, 9'd256, 32'h0);
    send_op(plp_pkg::CMD_INSERT, 9'd256, $urandom);
    send_op(plp_pkg::CMD_READ, 9'd1, 32'h0);
    wait_all_results();
  endtask

  task automatic test_stalled_results();
    int n;
    hold_off_req = 1'b1;
    for (n = 0; n < 8; n++) send_random_op();
    wait_all_results();
  endtask

  task automatic test_random_edits(int num_ops);
    int n;
    for (n = 0; n < num_ops; n++) send_random_op();
    wait_all_results();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_edits(50);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    list_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status %0d length %0d", $time, out_status, out_length);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatch_count++;
          end
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     out_read_value);
            mismatch_count++;
          end
          if (out_length !== want.length) begin
            $display("%0t: length expected %0d actual %0d", $time, want.length, out_length);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = plp_pkg::CMD_READ;
    in_position    = '0;
    in_value       = '0;
    list_len       = 0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    hold_off_req   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_edits();
    test_fill_to_full();
    test_stalled_results();
    test_random_edits(200);
    test_back_to_back();
    repeat (20) @(posedge clk);
    if (pending_results.size() == 0 && mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
